>>> sv/positional_doubly_linked_list_macros.svh
// Assertion helpers for the linked list block.
`ifndef POSITIONAL_DOUBLY_LINKED_LIST_MACROS_SVH
`define POSITIONAL_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PDLL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/pdll_pkg.sv
package pdll_pkg;
	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int POS_W    = 6;

	typedef enum logic [2:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_POS   = 3'd2,
		MODE_DEL_FRONT = 3'd3,
		MODE_DEL_BACK  = 3'd4,
		MODE_DEL_POS   = 3'd5,
		MODE_DISPLAY   = 3'd6,
		MODE_UNUSED    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// read address source
	typedef enum logic [1:0] {
		RD_HOLD = 2'd0,
		RD_HEAD = 2'd1,
		RD_FREE = 2'd2,
		RD_NEXT = 2'd3
	} rd_sel_t;

	typedef enum logic [3:0] {
		A_NONE      = 4'd0,
		A_INS_EMPTY = 4'd1,
		A_INS_FRONT = 4'd2,
		A_INS_BACK  = 4'd3,
		A_INS_MID   = 4'd4,
		A_FOUND     = 4'd5,
		A_LINK1     = 4'd6,
		A_LINK2     = 4'd7,
		A_DEL_LINK  = 4'd8,
		A_DEL_FREE  = 4'd9
	} act_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd;
		act_t    act;
		logic    first;
		logic    last;
		logic    single;
	} dp_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} dp_status_t;
endpackage

>>> sv/positional_doubly_linked_list.sv
// Positional doubly linked list of up to 32 words, with a free chain.
// Requests: start high while busy is low takes mode, value and position.
// busy stays high until the last result of the request has been shown.
// Results: each appears for exactly one cycle with strobe high; the receiver
// cannot stall, so every strobe cycle delivers one result.
// Display gives one result per stored element, head to tail, last_result on
// the final one; an empty list gives a single empty result. Every other mode
// gives one result with status and the new element_count.
// Steps from the accepting edge: every request is first decided; rejects and
// empty display answer straight after that, insert front/back after the free
// entry is taken, and positional requests after a walk of p links and the
// link updates. Display shows its first element after the decide step, then one per cycle.
// The walk over next links, one link per cycle through the registered read
// of the link memory, sets the positional cost, and the next request may
// start in the cycle busy falls.
// Reset empties the list at once: next-link memory contents are covered by
// per-entry valid bits, so there is no clearing pass.
module positional_doubly_linked_list import pdll_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        mode,
	input  logic [DATA_W-1:0] value,
	input  logic [POS_W-1:0]  position,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  element_count,
	output logic [DATA_W-1:0] read_value,
	output logic              read_valid,
	output logic              last_result
);
	dp_cmd_t cmd;
	dp_status_t sts;
	logic [DATA_W-1:0] rd_data;

	// sequencer: decides the request, walks links, steps the link updates
	pdll_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode), .position(position),
		.sts(sts), .cmd(cmd), .busy(busy), .strobe(strobe), .status(status),
		.read_valid(read_valid), .last_result(last_result)
	);

	// pointers, count and the three entry memories
	pdll_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .value(value),
		.sts(sts), .read_data(rd_data)
	);

	assign element_count = sts.count;
	// value is only meaningful while an element is shown
	assign read_value = read_valid ? rd_data : '0;
endmodule

>>> sv/pdll_ram.sv
module pdll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/pdll_datapath.sv
module pdll_datapath import pdll_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [DATA_W-1:0] value,
	output dp_status_t        sts,
	output logic [DATA_W-1:0] read_data
);
	logic [IDX_W-1:0] head_q, tail_q, free_q, cur_q, n_q, bef_q, aft_q;
	logic [CNT_W-1:0] count_q;
	logic [DATA_W-1:0] val_q;
	logic [CAPACITY-1:0] nvalid_q;
	logic nvrd_q;

	logic [IDX_W-1:0] raddr, nxt_ram, prv_rd, nxt_eff;
	logic v_we, n_we, p_we;
	logic [IDX_W-1:0] v_addr, n_addr, n_data, p_addr, p_data;

	// unwritten next links read as the reset free chain
	assign nxt_eff = nvrd_q ? nxt_ram : cur_q + IDX_W'(1);

	always_comb begin
		unique case (cmd.rd)
			RD_HOLD: raddr = cur_q;
			RD_HEAD: raddr = head_q;
			RD_FREE: raddr = free_q;
			RD_NEXT: raddr = nxt_eff;
			default: raddr = cur_q;
		endcase
	end

	always_comb begin
		v_we = 1'b0; v_addr = free_q;
		n_we = 1'b0; n_addr = free_q; n_data = free_q;
		p_we = 1'b0; p_addr = free_q; p_data = free_q;
		unique case (cmd.act)
			A_INS_EMPTY: begin
				v_we = 1'b1;
				n_we = 1'b1;
				p_we = 1'b1;
			end
			A_INS_FRONT: begin
				v_we = 1'b1;
				n_we = 1'b1; n_data = head_q;
				p_we = 1'b1; p_addr = head_q;
			end
			A_INS_BACK: begin
				v_we = 1'b1;
				p_we = 1'b1; p_data = tail_q;
				n_we = 1'b1; n_addr = tail_q;
			end
			A_INS_MID: v_we = 1'b1;
			A_LINK1: begin
				n_we = 1'b1; n_addr = bef_q; n_data = n_q;
				p_we = 1'b1; p_addr = n_q; p_data = bef_q;
			end
			A_LINK2: begin
				n_we = 1'b1; n_addr = n_q; n_data = cur_q;
				p_we = 1'b1; p_addr = cur_q; p_data = n_q;
			end
			A_DEL_LINK: begin
				if (!cmd.single) begin
					n_we = !cmd.first; n_addr = bef_q; n_data = aft_q;
					p_we = !cmd.last;  p_addr = aft_q; p_data = bef_q;
				end
			end
			A_DEL_FREE: begin
				n_we = 1'b1; n_addr = cur_q; n_data = free_q;
			end
			default: ;
		endcase
	end

	pdll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(v_we), .waddr(v_addr), .wdata(val_q),
		.raddr(raddr), .rdata(read_data)
	);
	pdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(n_we), .waddr(n_addr), .wdata(n_data),
		.raddr(raddr), .rdata(nxt_ram)
	);
	pdll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_addr), .wdata(p_data),
		.raddr(raddr), .rdata(prv_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end
		if (cmd.act == A_FOUND) begin
			bef_q <= prv_rd;
			aft_q <= nxt_eff;
		end
		if (cmd.act == A_INS_MID) begin
			n_q <= free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			free_q   <= '0;
			cur_q    <= '0;
			count_q  <= '0;
			nvalid_q <= '0;
			nvrd_q   <= 1'b0;
		end else begin
			cur_q  <= raddr;
			nvrd_q <= nvalid_q[raddr];
			if (n_we) begin
				nvalid_q[n_addr] <= 1'b1;
			end
			unique case (cmd.act)
				A_INS_EMPTY: begin
					free_q <= nxt_eff; head_q <= free_q; tail_q <= free_q;
					count_q <= count_q + CNT_W'(1);
				end
				A_INS_FRONT: begin
					free_q <= nxt_eff; head_q <= free_q;
					count_q <= count_q + CNT_W'(1);
				end
				A_INS_BACK: begin
					free_q <= nxt_eff; tail_q <= free_q;
					count_q <= count_q + CNT_W'(1);
				end
				A_INS_MID: free_q <= nxt_eff;
				A_LINK2: count_q <= count_q + CNT_W'(1);
				A_DEL_LINK: begin
					if (cmd.single) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						if (cmd.first) head_q <= aft_q;
						if (cmd.last)  tail_q <= bef_q;
					end
				end
				A_DEL_FREE: begin
					free_q  <= cur_q;
					count_q <= count_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	assign sts.count = count_q;
endmodule

>>> sv/pdll_ctrl.sv
module pdll_ctrl import pdll_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       mode,
	input  logic [POS_W-1:0] position,
	input  dp_status_t       sts,
	output dp_cmd_t          cmd,
	output logic             busy,
	output logic             strobe,
	output logic [1:0]       status,
	output logic             read_valid,
	output logic             last_result
);
	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_DECIDE   = 10'b0000000010,
		S_INS_TAKE = 10'b0000000100,
		S_WALK     = 10'b0000001000,
		S_LINK1    = 10'b0000010000,
		S_LINK2    = 10'b0000100000,
		S_DEL_LINK = 10'b0001000000,
		S_DEL_FREE = 10'b0010000000,
		S_RESP     = 10'b0100000000,
		S_DISP     = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	mode_t mode_q;
	logic [POS_W-1:0] pos_q, pos_d, idx_q, idx_d;
	status_t st_q, st_d;
	logic [CNT_W-1:0] cnt, cnt1;
	logic is_ins;

	assign cnt  = sts.count;
	assign cnt1 = cnt + CNT_W'(1);
	assign is_ins = (mode_q == MODE_INS_FRONT) || (mode_q == MODE_INS_BACK) ||
		(mode_q == MODE_INS_POS);

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		st_d    = st_q;
		cmd     = '{load: 1'b0, rd: RD_HOLD, act: A_NONE, first: (pos_q == POS_W'(1)),
			last: (pos_q == POS_W'(cnt)), single: (cnt == CNT_W'(1))};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				st_d    = ST_OK;
				state_d = S_RESP;
				unique case (mode_q) inside
					MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
						pos_d = (mode_q == MODE_INS_FRONT) ? POS_W'(1) :
							(mode_q == MODE_INS_BACK) ? POS_W'(cnt1) : pos_q;
						if (pos_d == '0 || pos_d > POS_W'(cnt1)) begin
							st_d = ST_REJECT;
						end else if (cnt >= CNT_W'(CAPACITY)) begin
							st_d = ST_FULL;
						end else begin
							cmd.rd  = RD_FREE;
							state_d = S_INS_TAKE;
						end
					end
					MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
						pos_d = (mode_q == MODE_DEL_FRONT) ? POS_W'(1) :
							(mode_q == MODE_DEL_BACK) ? POS_W'(cnt) : pos_q;
						if (cnt == '0 || pos_d == '0 || pos_d > POS_W'(cnt)) begin
							st_d = ST_REJECT;
						end else begin
							cmd.rd  = RD_HEAD;
							idx_d   = POS_W'(1);
							state_d = S_WALK;
						end
					end
					MODE_DISPLAY: begin
						if (cnt != '0) begin
							cmd.rd  = RD_HEAD;
							idx_d   = POS_W'(1);
							state_d = S_DISP;
						end
					end
					default: st_d = ST_REJECT;
				endcase
			end
			S_INS_TAKE: begin
				state_d = S_RESP;
				if (cnt == '0) begin
					cmd.act = A_INS_EMPTY;
				end else if (pos_q == POS_W'(1)) begin
					cmd.act = A_INS_FRONT;
				end else if (pos_q == POS_W'(cnt1)) begin
					cmd.act = A_INS_BACK;
				end else begin
					cmd.act = A_INS_MID;
					cmd.rd  = RD_HEAD;
					idx_d   = POS_W'(1);
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (idx_q == pos_q) begin
					cmd.act = A_FOUND;
					state_d = is_ins ? S_LINK1 : S_DEL_LINK;
				end else begin
					cmd.rd = RD_NEXT;
					idx_d  = idx_q + POS_W'(1);
				end
			end
			S_LINK1: begin
				cmd.act = A_LINK1;
				state_d = S_LINK2;
			end
			S_LINK2: begin
				cmd.act = A_LINK2;
				state_d = S_RESP;
			end
			S_DEL_LINK: begin
				cmd.act = A_DEL_LINK;
				state_d = S_DEL_FREE;
			end
			S_DEL_FREE: begin
				cmd.act = A_DEL_FREE;
				state_d = S_RESP;
			end
			S_RESP: state_d = S_IDLE;
			S_DISP: begin
				if (idx_q == POS_W'(cnt)) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd = RD_NEXT;
					idx_d  = idx_q + POS_W'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode_t'(mode);
			pos_q  <= position;
		end else begin
			pos_q <= pos_d;
		end
		idx_q <= idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = (state_q == S_RESP) || (state_q == S_DISP);
	assign read_valid  = (state_q == S_DISP);
	assign status      = (state_q == S_DISP) ? ST_OK : st_q;
	assign last_result = (state_q == S_RESP) || (idx_q == POS_W'(cnt));
endmodule

>>> sv/pdll_checker.sv
`include "positional_doubly_linked_list_macros.svh"

module pdll_checker import pdll_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [1:0]        status,
	input logic              read_valid,
	input logic              last_result
);
	`PDLL_ASSERT_NOW(a_strobe_busy, strobe, busy, "result outside a request")
	`PDLL_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
	`PDLL_ASSERT_NEXT(a_disp_run, strobe && !last_result, strobe && read_valid, "display broken")
	`PDLL_ASSERT_NOW(a_disp_ok, strobe && read_valid, status == ST_OK, "display with bad status")
	`PDLL_ASSERT_NOW(a_single_last, strobe && !read_valid, last_result, "lone result not last")
endmodule

bind positional_doubly_linked_list pdll_checker u_pdll_checker (.*);
